// ===== hw/rtl/steering_force_calc_unit_macros.svh =====
// Assertion macros shared by the steering force RTL.
// Needs clk and rst_n in the scope of each use.
`ifndef STEERING_FORCE_CALC_UNIT_MACROS_SVH
`define STEERING_FORCE_CALC_UNIT_MACROS_SVH

// same-cycle implication
`define SFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/sfc_pkg.sv =====
// Types, widths and constants of the steering force pipeline.
// No dependencies.
package sfc_pkg;

    localparam int WORD_W      = 32;
    localparam int MAG_W       = 33;
    localparam int SQ_W        = 66;
    localparam int ROOT_W      = 35;
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int REM_W       = ROOT_W + 3;
    localparam int Q_W         = 31;
    localparam int DIVN_W      = 63;
    localparam int DIVV_W      = 35;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int DIV_STAGES  = Q_W;
    localparam int SUM_W       = 36;
    localparam int DEC_W       = 10;
    localparam int CFG_W       = 31;
    localparam int IDX_W       = 2;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [MAG_W-1:0]         mag_t;
    typedef logic [SQ_W-1:0]          sq_t;
    typedef logic [ROOT_W-1:0]        root_t;
    typedef logic [Q_W-1:0]           quo_t;
    typedef logic [DIVN_W-1:0]        divn_t;
    typedef logic [DIVV_W-1:0]        divv_t;

    typedef enum logic [IDX_W-1:0] {
        REG_ENABLE = 2'd0,
        REG_MAX_SPEED = 2'd1,
        REG_DECEL = 2'd2,
        REG_PANIC = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic              vld;
        logic [2:0]        neg;
        mag_t [2:0]        mag;
        word_t [2:0]       vel;
    } side_a_t;

    typedef struct packed {
        logic              vld;
        logic [2:0]        neg;
        mag_t [2:0]        mag;
        word_t [2:0]       vel;
        root_t             dlen;
    } side_b_t;

    typedef struct packed {
        logic              vld;
        logic [2:0]        neg;
        word_t [2:0]       vel;
        root_t             dlen;
    } side_c_t;

    // rate / 0.005; rate 0 acts as 1
    function automatic logic [DEC_W-1:0] decel_div(input logic [1:0] rate);
        logic [DEC_W-1:0] v;
        unique case (rate)
            2'd0, 2'd1: v = DEC_W'(200);
            2'd2:       v = DEC_W'(400);
            default:    v = DEC_W'(600);
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/sfc_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
// Uses sfc_pkg.
module sfc_sqrt import sfc_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  sq_t   radicand,
    output root_t root
);

    logic [REM_W-1:0] rem_reg  [SQRT_STAGES];
    root_t            root_reg [SQRT_STAGES];
    logic [RAD_W-1:0] rad_reg  [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [REM_W-1:0] rem_in;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        root_t            root_in;
        logic [RAD_W-1:0] rad_in;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = {{(RAD_W-SQ_W){1'b0}}, radicand};
        end
        else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k] <= {rad_in[RAD_W-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg[k]  <= rem_sh - trial;
                    root_reg[k] <= {root_in[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= rem_sh;
                    root_reg[k] <= {root_in[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign root = root_reg[SQRT_STAGES-1];

endmodule

// ===== hw/rtl/sfc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit Q_W bits. Uses sfc_pkg.
module sfc_div import sfc_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  divn_t dividend,
    input  divv_t divisor,
    output quo_t  quotient
);

    divv_t  rem_reg [DIV_STAGES];
    quo_t   low_reg [DIV_STAGES];
    divv_t  div_reg [DIV_STAGES];
    quo_t   q_reg   [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        divv_t             rem_in;
        quo_t              low_in;
        divv_t             div_in;
        quo_t              q_in;
        logic [DIVV_W:0]   sh;
        logic [DIVV_W:0]   diff;

        if (k == 0) begin : g_first
            assign rem_in = DIVV_W'(dividend[DIVN_W-1:Q_W]);
            assign low_in = dividend[Q_W-1:0];
            assign div_in = divisor;
            assign q_in   = '0;
        end
        else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign div_in = div_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        assign sh   = {rem_in, low_in[Q_W-1]};
        assign diff = sh - {1'b0, div_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                low_reg[k] <= {low_in[Q_W-2:0], 1'b0};
                div_reg[k] <= div_in;
                if (sh >= {1'b0, div_in})
                begin
                    rem_reg[k] <= diff[DIVV_W-1:0];
                    q_reg[k]   <= {q_in[Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= sh[DIVV_W-1:0];
                    q_reg[k]   <= {q_in[Q_W-2:0], 1'b0};
                end
            end
        end
    end

    assign quotient = q_reg[DIV_STAGES-1];

endmodule

// ===== hw/rtl/steering_force_calc_unit.sv =====
// Steering force unit: seek, arrive and flee forces of one agent per beat.
// Uses sfc_pkg, sfc_sqrt, sfc_div and the assertion macros header.
//
// Input channel in_valid/in_ready carries position, velocity and target,
// signed Q16.16. Output channel out_valid/out_ready carries the saturated
// force sum. Both are valid/ready; a beat moves when both are high.
// The input beat passes through 103 register stages: offsets, squares,
// sum (3), square root (35 stages), arrive speed divide (31), clamp and
// products (2), six parallel divides (31), final sum and saturation (1).
// Throughput is one agent per cycle while out_ready keeps the pipeline
// moving; every stage takes a new beat each cycle unless it is stalled.
// The user must write registers through cfg_we/cfg_index/cfg_data only while
// idle; the block does not enforce it. 0 enable bits, 1 max speed,
// 2 deceleration, 3 panic distance. Reset clears all valid bits and loads
// the register defaults. When the receiver stalls the whole pipeline holds
// in place; in_ready drops in the same cycle and nothing is lost or repeated.
`include "steering_force_calc_unit_macros.svh"
module steering_force_calc_unit import sfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  word_t                pos_x,
    input  word_t                pos_y,
    input  word_t                pos_z,
    input  word_t                vel_x,
    input  word_t                vel_y,
    input  word_t                vel_z,
    input  word_t                target_x,
    input  word_t                target_y,
    input  word_t                target_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output word_t                force_x,
    output word_t                force_y,
    output word_t                force_z
);

    logic [2:0]       enable_reg;
    logic [CFG_W-1:0] max_speed_reg;
    logic [1:0]       decel_reg;
    logic [CFG_W-1:0] panic_reg;

    logic             en;
    logic             out_valid_reg;
    word_t [2:0]      force_reg;
    word_t [2:0]      force_next;

    side_a_t          a_reg, b_reg, c_reg, a_next;
    sq_t   [2:0]      sq_reg;
    sq_t              sumsq_reg;
    side_a_t          sa_reg [SQRT_STAGES];
    side_b_t          sb_reg [DIV_STAGES];
    side_b_t          f_reg, g_reg;
    side_c_t          sc_reg [DIV_STAGES];
    root_t            root;
    quo_t             spd_raw;
    quo_t             spd_reg;
    divn_t [2:0]      prod_s_reg;
    divn_t [2:0]      prod_a_reg;
    quo_t  [2:0]      q_s;
    quo_t  [2:0]      q_a;
    word_t [2:0]      pos_v, tgt_v, vel_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= '0;
            max_speed_reg <= CFG_W'(65536);
            decel_reg     <= 2'd2;
            panic_reg     <= CFG_W'(6553600);
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_ENABLE:    enable_reg    <= cfg_data[2:0];
                REG_MAX_SPEED: max_speed_reg <= cfg_data;
                REG_DECEL:     decel_reg     <= cfg_data[1:0];
                REG_PANIC:     panic_reg     <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign pos_v = {pos_z, pos_y, pos_x};
    assign tgt_v = {target_z, target_y, target_x};
    assign vel_v = {vel_z, vel_y, vel_x};

    always_comb
    begin
        logic signed [MAG_W-1:0] d;
        a_next.vld = in_valid;
        for (int i = 0; i < 3; i++)
        begin
            d = {tgt_v[i][WORD_W-1], tgt_v[i]} - {pos_v[i][WORD_W-1], pos_v[i]};
            a_next.neg[i] = d[MAG_W-1];
            a_next.mag[i] = d[MAG_W-1] ? mag_t'(-d) : mag_t'(d);
            a_next.vel[i] = vel_v[i];
        end
    end

    // side lines carry valid bits, so they take the reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
            f_reg <= '0;
            g_reg <= '0;
            for (int k = 0; k < SQRT_STAGES; k++)
            begin
                sa_reg[k] <= '0;
            end
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                sb_reg[k] <= '0;
                sc_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            a_reg     <= a_next;
            b_reg     <= a_reg;
            c_reg     <= b_reg;
            sa_reg[0] <= c_reg;
            for (int k = 1; k < SQRT_STAGES; k++)
            begin
                sa_reg[k] <= sa_reg[k-1];
            end
            sb_reg[0] <= {sa_reg[SQRT_STAGES-1], root};
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                sb_reg[k] <= sb_reg[k-1];
                sc_reg[k] <= sc_reg[k-1];
            end
            f_reg     <= sb_reg[DIV_STAGES-1];
            g_reg     <= f_reg;
            sc_reg[0] <= '{vld: g_reg.vld, neg: g_reg.neg, vel: g_reg.vel, dlen: g_reg.dlen};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i]     <= sq_t'(a_reg.mag[i]) * sq_t'(a_reg.mag[i]);
                prod_s_reg[i] <= DIVN_W'({{(Q_W){1'b0}}, f_reg.mag[i]}
                                         * {{(MAG_W){1'b0}}, max_speed_reg});
                prod_a_reg[i] <= DIVN_W'({{(Q_W){1'b0}}, f_reg.mag[i]}
                                         * {{(MAG_W){1'b0}}, spd_reg});
            end
            sumsq_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            spd_reg   <= (spd_raw > max_speed_reg) ? max_speed_reg : spd_raw;
        end
    end

    sfc_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (sumsq_reg),
        .root     (root)
    );

    sfc_div u_div_spd (
        .clk      (clk),
        .en       (en),
        .dividend ({{(DIVN_W-ROOT_W){1'b0}}, root}),
        .divisor  ({{(DIVV_W-DEC_W){1'b0}}, decel_div(decel_reg)}),
        .quotient (spd_raw)
    );

    for (genvar i = 0; i < 3; i++) begin : g_comp
        sfc_div u_div_s (
            .clk      (clk),
            .en       (en),
            .dividend (prod_s_reg[i]),
            .divisor  (g_reg.dlen),
            .quotient (q_s[i])
        );
        sfc_div u_div_a (
            .clk      (clk),
            .en       (en),
            .dividend (prod_a_reg[i]),
            .divisor  (g_reg.dlen),
            .quotient (q_a[i])
        );
    end

    always_comb
    begin
        side_c_t                 sc;
        logic                    dist_nz;
        logic signed [SUM_W-1:0] qs_s;
        logic signed [SUM_W-1:0] qa_s;
        logic signed [SUM_W-1:0] vel_e;
        logic signed [SUM_W-1:0] tot;
        sc      = sc_reg[DIV_STAGES-1];
        dist_nz = (sc.dlen != '0);
        for (int i = 0; i < 3; i++)
        begin
            qs_s  = dist_nz ? $signed({{(SUM_W-Q_W){1'b0}}, q_s[i]}) : '0;
            qa_s  = $signed({{(SUM_W-Q_W){1'b0}}, q_a[i]});
            if (sc.neg[i])
            begin
                qs_s = -qs_s;
                qa_s = -qa_s;
            end
            vel_e = SUM_W'(sc.vel[i]);
            tot   = '0;
            if (enable_reg[0])
            begin
                tot = tot + qs_s - vel_e;
            end
            if (enable_reg[1] && dist_nz)
            begin
                tot = tot + qa_s - vel_e;
            end
            if (enable_reg[2] && (sc.dlen <= {{(ROOT_W-CFG_W){1'b0}}, panic_reg}))
            begin
                tot = tot - qs_s - vel_e;
            end
            if (tot > $signed(SUM_W'(32'h7fff_ffff)))
            begin
                force_next[i] = 32'h7fff_ffff;
            end
            else if (tot < -$signed(SUM_W'(33'h0_8000_0000)))
            begin
                force_next[i] = 32'h8000_0000;
            end
            else
            begin
                force_next[i] = tot[WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= sc_reg[DIV_STAGES-1].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            force_reg <= force_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign force_x   = force_reg[0];
    assign force_y   = force_reg[1];
    assign force_z   = force_reg[2];

    `SFC_ASSERT_NEXT(a_last_to_out, en && sc_reg[DIV_STAGES-1].vld, out_valid, "last stage beat not presented")
    `SFC_ASSERT_NEXT(a_stall_hold, !en, $stable(a_reg) && $stable(sc_reg[0]), "pipeline moved while stalled")
    `SFC_ASSERT_NEXT(a_cfg_enable, cfg_we && (cfg_index == REG_ENABLE), enable_reg == $past(cfg_data[2:0]), "enable write lost")

endmodule
